// ===== rtl/wsfr_pkg.sv =====
// Shared types and constants for the WebSocket frame receiver.
package wsfr_pkg;

    localparam int LENGTH_BITS = 32;

    typedef logic [LENGTH_BITS-1:0] len_t;

    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd4096;

    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'h7F;

    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;
    localparam logic [1:0] MASK_LAST  = 2'd3;

    typedef enum logic [2:0] {
        ST_HDR1 = 3'd0,
        ST_HDR2 = 3'd1,
        ST_EXT  = 3'd2,
        ST_MASK = 3'd3,
        ST_PAY  = 3'd4
    } stage_t;

    typedef enum logic [1:0] {
        RK_TEXT  = 2'd0,
        RK_EMPTY = 2'd1,
        RK_PONG  = 2'd2,
        RK_CLOSE = 2'd3
    } rk_t;

    // Work item handed from the parser to the output side.
    typedef struct packed {
        rk_t        kind;
        logic [7:0] raw;
        logic [7:0] key;
        logic       last;
    } item_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } q_stat_t;

endpackage

// ===== rtl/wsfr_front.sv =====
// Frame parser: header, extended length, mask key and payload tracking.
module wsfr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                kind,
    input  logic [7:0]          rx_byte,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata,
    output logic                push,
    output wsfr_pkg::item_t     item
);

    localparam int LB = wsfr_pkg::LENGTH_BITS;

    wsfr_pkg::stage_t stage_reg, stage_next;
    logic [31:0]      max_reg;
    logic [7:0]       first_reg, first_next;
    logic [3:0]       op_reg, op_next;
    logic             mask_reg, mask_next;
    logic             skip_reg, skip_next;
    logic             close_reg, close_next;
    logic             is64_reg, is64_next;
    logic [2:0]       ext_cnt_reg, ext_cnt_next;
    wsfr_pkg::len_t   len_acc_reg, len_acc_next;
    logic             ovf_reg, ovf_next;
    logic [1:0]       mask_cnt_reg, mask_cnt_next;
    logic [1:0]       key_idx_reg, key_idx_next;
    wsfr_pkg::len_t   remaining_reg, remaining_next;
    logic [7:0]       key_reg [4];

    logic             byte_acc;
    wsfr_pkg::len_t   acc_shift;
    logic             ovf_new;
    logic             hdr2_short;
    logic             ext_done;
    logic             len_known;
    wsfr_pkg::len_t   len_value;
    logic             mask_now;
    logic [3:0]       op_now;
    logic             skip_base;
    logic             close_now;
    logic             enter_pay;
    wsfr_pkg::len_t   pay_len;
    logic             skip_eff;
    logic             empty;
    logic             pay_last;
    logic             emit_text;
    logic             skip_now;
    logic             fin_valid;
    wsfr_pkg::rk_t    fin_kind;

    assign byte_acc   = in_valid && in_ready && !kind;
    assign acc_shift  = {len_acc_reg[LB-9:0], rx_byte};
    assign ovf_new    = ovf_reg || (len_acc_reg[LB-1:LB-8] != 8'd0);
    assign hdr2_short = (stage_reg == wsfr_pkg::ST_HDR2) && (rx_byte[6:0] < wsfr_pkg::LEN7_EXT16);
    assign ext_done   = (stage_reg == wsfr_pkg::ST_EXT)
                     && (ext_cnt_reg == (is64_reg ? wsfr_pkg::EXT64_LAST : wsfr_pkg::EXT16_LAST));
    assign len_known  = hdr2_short || ext_done;
    assign len_value  = hdr2_short ? LB'(rx_byte[6:0]) : (ovf_new ? '1 : acc_shift);

    assign mask_now   = (stage_reg == wsfr_pkg::ST_HDR2) ? rx_byte[7] : mask_reg;
    assign op_now     = (stage_reg == wsfr_pkg::ST_HDR2) ? first_reg[3:0] : op_reg;
    assign skip_base  = (stage_reg == wsfr_pkg::ST_HDR2) ? !first_reg[7] : skip_reg;
    assign close_now  = (stage_reg == wsfr_pkg::ST_HDR2) ? (first_reg[3:0] == wsfr_pkg::OP_CLOSE)
                                                          : close_reg;

    assign enter_pay  = (len_known && !mask_now)
                     || ((stage_reg == wsfr_pkg::ST_MASK) && (mask_cnt_reg == wsfr_pkg::MASK_LAST));
    assign pay_len    = (stage_reg == wsfr_pkg::ST_MASK) ? remaining_reg : len_value;
    assign skip_eff   = skip_base || (pay_len > wsfr_pkg::len_t'(max_reg));
    assign empty      = enter_pay && (pay_len == '0);

    assign pay_last   = (stage_reg == wsfr_pkg::ST_PAY) && (remaining_reg == LB'(1));
    assign emit_text  = (stage_reg == wsfr_pkg::ST_PAY) && !skip_reg && !close_reg
                     && (op_reg == wsfr_pkg::OP_TEXT);
    assign skip_now   = (stage_reg == wsfr_pkg::ST_PAY) ? skip_reg : skip_eff;

    always_comb
    begin
        fin_valid = 1'b0;
        fin_kind  = wsfr_pkg::RK_CLOSE;
        if (empty || (pay_last && !emit_text))
        begin
            if (close_now)
            begin
                fin_valid = 1'b1;
                fin_kind  = wsfr_pkg::RK_CLOSE;
            end
            else if (!skip_now && op_now == wsfr_pkg::OP_PING)
            begin
                fin_valid = 1'b1;
                fin_kind  = wsfr_pkg::RK_PONG;
            end
            else if (!skip_now && op_now == wsfr_pkg::OP_TEXT && empty)
            begin
                fin_valid = 1'b1;
                fin_kind  = wsfr_pkg::RK_EMPTY;
            end
        end
    end

    // next stage
    always_comb
    begin
        stage_next = stage_reg;
        if (in_valid && in_ready)
        begin
            if (kind)
            begin
                stage_next = wsfr_pkg::ST_HDR1;
            end
            else
            begin
                unique case (stage_reg)
                    wsfr_pkg::ST_HDR2:
                    begin
                        if (!hdr2_short)
                            stage_next = wsfr_pkg::ST_EXT;
                        else if (mask_now)
                            stage_next = wsfr_pkg::ST_MASK;
                        else if (empty)
                            stage_next = wsfr_pkg::ST_HDR1;
                        else
                            stage_next = wsfr_pkg::ST_PAY;
                    end
                    wsfr_pkg::ST_EXT:
                    begin
                        if (ext_done)
                        begin
                            if (mask_now)
                                stage_next = wsfr_pkg::ST_MASK;
                            else if (empty)
                                stage_next = wsfr_pkg::ST_HDR1;
                            else
                                stage_next = wsfr_pkg::ST_PAY;
                        end
                    end
                    wsfr_pkg::ST_MASK:
                    begin
                        if (enter_pay)
                            stage_next = empty ? wsfr_pkg::ST_HDR1 : wsfr_pkg::ST_PAY;
                    end
                    wsfr_pkg::ST_PAY:
                    begin
                        if (pay_last)
                            stage_next = wsfr_pkg::ST_HDR1;
                    end
                    default:
                    begin
                        stage_next = wsfr_pkg::ST_HDR2;
                    end
                endcase
            end
        end
    end

    // datapath next values
    always_comb
    begin
        first_next     = first_reg;
        op_next        = op_reg;
        mask_next      = mask_reg;
        skip_next      = skip_reg;
        close_next     = close_reg;
        is64_next      = is64_reg;
        ext_cnt_next   = ext_cnt_reg;
        len_acc_next   = len_acc_reg;
        ovf_next       = ovf_reg;
        mask_cnt_next  = mask_cnt_reg;
        key_idx_next   = key_idx_reg;
        remaining_next = remaining_reg;
        if (byte_acc)
        begin
            unique case (stage_reg)
                wsfr_pkg::ST_HDR2:
                begin
                    op_next      = first_reg[3:0];
                    mask_next    = rx_byte[7];
                    skip_next    = !first_reg[7];
                    close_next   = (first_reg[3:0] == wsfr_pkg::OP_CLOSE);
                    is64_next    = (rx_byte[6:0] == wsfr_pkg::LEN7_EXT64);
                    ext_cnt_next = 3'd0;
                    len_acc_next = '0;
                    ovf_next     = 1'b0;
                end
                wsfr_pkg::ST_EXT:
                begin
                    len_acc_next = acc_shift;
                    ovf_next     = ovf_new;
                    ext_cnt_next = ext_cnt_reg + 3'd1;
                end
                wsfr_pkg::ST_MASK:
                begin
                    mask_cnt_next = mask_cnt_reg + 2'd1;
                end
                wsfr_pkg::ST_PAY:
                begin
                    remaining_next = remaining_reg - LB'(1);
                    key_idx_next   = key_idx_reg + 2'd1;
                end
                default:
                begin
                    first_next = rx_byte;
                end
            endcase
            if (len_known && mask_now)
            begin
                remaining_next = len_value;
                mask_cnt_next  = 2'd0;
            end
            if (enter_pay)
            begin
                remaining_next = pay_len;
                key_idx_next   = 2'd0;
                skip_next      = skip_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= wsfr_pkg::ST_HDR1;
            max_reg   <= wsfr_pkg::MAX_PAYLOAD_RESET;
        end
        else
        begin
            stage_reg <= stage_next;
            if (cfg_we)
                max_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg     <= first_next;
        op_reg        <= op_next;
        mask_reg      <= mask_next;
        skip_reg      <= skip_next;
        close_reg     <= close_next;
        is64_reg      <= is64_next;
        ext_cnt_reg   <= ext_cnt_next;
        len_acc_reg   <= len_acc_next;
        ovf_reg       <= ovf_next;
        mask_cnt_reg  <= mask_cnt_next;
        key_idx_reg   <= key_idx_next;
        remaining_reg <= remaining_next;
        if (byte_acc && stage_reg == wsfr_pkg::ST_MASK)
            key_reg[mask_cnt_reg] <= rx_byte;
    end

    assign push = byte_acc && (emit_text || fin_valid);

    always_comb
    begin
        item.kind = emit_text ? wsfr_pkg::RK_TEXT : fin_kind;
        item.raw  = emit_text ? rx_byte : 8'd0;
        item.key  = (emit_text && mask_reg) ? key_reg[key_idx_reg] : 8'd0;
        item.last = emit_text && pay_last;
    end

endmodule

// ===== rtl/wsfr_queue.sv =====
// Two-entry queue between the parser and the output stage.
module wsfr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  wsfr_pkg::item_t     push_item,
    input  logic                pop,
    output wsfr_pkg::item_t     head,
    output wsfr_pkg::q_stat_t   stat
);

    wsfr_pkg::item_t mem_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = !wr_ptr_reg;
        if (pop)
            rd_ptr_next = !rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    assign head          = mem_reg[rd_ptr_reg];
    assign stat.full     = count_reg[1];
    assign stat.nonempty = (count_reg != 2'd0);

endmodule

// ===== rtl/wsfr_back.sv =====
// Output stage: payload unmasking and the result register.
module wsfr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  wsfr_pkg::item_t     head,
    input  wsfr_pkg::q_stat_t   stat,
    output logic                pop,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [1:0]          result_kind,
    output logic [7:0]          data_byte,
    output logic                last_of_message
);

    logic          valid_reg, valid_next;
    wsfr_pkg::rk_t kind_reg;
    logic [7:0]    data_reg;
    logic          last_reg;

    assign pop        = stat.nonempty && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= head.kind;
            data_reg <= head.raw ^ head.key;
            last_reg <= head.last;
        end
    end

    assign out_valid       = valid_reg;
    assign result_kind     = kind_reg;
    assign data_byte       = data_reg;
    assign last_of_message = last_reg;

endmodule

// ===== rtl/websocket_frame_receiver.sv =====
// Top level of the WebSocket frame receiver.
//
// Input channel (in_valid/in_ready): one item per transfer, either a received
// stream byte (kind 0, rx_byte) or a disconnect (kind 1) that restarts the
// frame parse. Output channel (out_valid/out_ready): one result per transfer:
// an unmasked text payload byte with last_of_message on the final byte, an
// empty text message, a pong request or a close request. Bytes that give no
// result produce no output transfer.
// Throughput is one input byte per cycle while in_ready is high; the parser
// decides each byte in the cycle it is taken. A result is written into the
// two-entry queue at its input transfer and moves to the output register when
// the queue pops it, which waits while the output is stalled.
// When the output stalls, the queue keeps taking results; in_ready drops only
// while both queue entries are occupied.
// cfg_we/cfg_wdata write max_payload_bytes (reset value 4096); write it only
// while no frame byte is in flight. After reset the parser expects the first
// header byte and the queue and output are empty.
module websocket_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [7:0]  data_byte,
    output logic        last_of_message
);

    logic              push;
    logic              pop;
    wsfr_pkg::item_t   push_item;
    wsfr_pkg::item_t   head;
    wsfr_pkg::q_stat_t stat;

    assign in_ready = !stat.full;

    wsfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .rx_byte   (rx_byte),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .item      (push_item)
    );

    wsfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .stat      (stat)
    );

    wsfr_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .stat            (stat),
        .pop             (pop),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .result_kind     (result_kind),
        .data_byte       (data_byte),
        .last_of_message (last_of_message)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("queue written while full");

    a_disc_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && kind) |-> !push)
        else $error("disconnect produced a result");

    a_ctrl_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind != wsfr_pkg::RK_TEXT) |-> (data_byte == 8'd0 && !last_of_message))
        else $error("control result carries payload fields");

    a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid)
        else $error("output register not loaded after queue pop");

endmodule
